FILE: hw/rtl/lxgcd_pkg.sv
package lxgcd_pkg;

    localparam int WORD_BITS_DEF = 128;
    localparam int LEAD_BITS_DEF = 63;
    localparam int HALF_BITS     = 64;
    localparam int HI_BITS       = 63;
    localparam int IN_BITS       = HI_BITS + HALF_BITS;
    localparam int COEF_BITS     = 64;

    typedef logic [HALF_BITS-1:0] t_half;
    typedef logic [COEF_BITS-1:0] t_coef;

endpackage

FILE: hw/rtl/lxgcd_div.sv
// Restoring divider, one quotient bit per cycle. Alongside the division it
// builds q*i_q and q*i_s by Horner accumulation and returns i_p - q*i_q and
// i_r - q*i_s, all modulo 2^W.
module lxgcd_div import lxgcd_pkg::*; #(
    parameter int W = WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  logic [$clog2(W)-1:0] i_top,
    input  logic [W-1:0]         i_a,
    input  logic [W-1:0]         i_d,
    input  logic [W-1:0]         i_p,
    input  logic [W-1:0]         i_q,
    input  logic [W-1:0]         i_r,
    input  logic [W-1:0]         i_s,
    output logic                 o_done,
    output logic [W-1:0]         o_rem,
    output logic [W-1:0]         o_p,
    output logic [W-1:0]         o_r
);

    localparam int IW = $clog2(W);

    logic          r_busy;
    logic          r_done;
    logic [IW-1:0] r_cnt;
    logic [W-1:0]  r_a, r_d, r_p, r_q, r_r, r_s, r_rem, r_pq, r_ps;
    logic [W:0]    sh;
    logic          ge;

    assign sh = {r_rem, r_a[r_cnt]};
    assign ge = (sh >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= i_top;
                r_a    <= i_a;
                r_d    <= i_d;
                r_p    <= i_p;
                r_q    <= i_q;
                r_r    <= i_r;
                r_s    <= i_s;
                r_rem  <= '0;
                r_pq   <= '0;
                r_ps   <= '0;
            end else if (r_busy) begin
                r_rem <= ge ? W'(sh - {1'b0, r_d}) : W'(sh);
                r_pq  <= (r_pq << 1) + (ge ? r_q : '0);
                r_ps  <= (r_ps << 1) + (ge ? r_s : '0);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
    assign o_p    = r_p - r_pq;
    assign o_r    = r_r - r_ps;

endmodule

FILE: hw/rtl/lxgcd_mac.sv
// Serial multiply-accumulate: o_acc = i_ca*i_a + i_cb*i_b modulo 2^W, with
// signed 64-bit coefficients, one coefficient bit per cycle.
module lxgcd_mac import lxgcd_pkg::*; #(
    parameter int W = WORD_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_go,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  t_coef        i_ca,
    input  t_coef        i_cb,
    output logic         o_done,
    output logic [W-1:0] o_acc
);

    localparam int CW = $clog2(COEF_BITS);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_ta, r_tb, r_acc;
    t_coef         r_ma, r_mb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                // Fold each coefficient's sign into its operand.
                r_busy <= 1'b1;
                r_cnt  <= CW'(COEF_BITS - 1);
                r_ta   <= i_ca[COEF_BITS-1] ? W'(-i_a) : i_a;
                r_tb   <= i_cb[COEF_BITS-1] ? W'(-i_b) : i_b;
                r_ma   <= i_ca[COEF_BITS-1] ? t_coef'(-i_ca) : i_ca;
                r_mb   <= i_cb[COEF_BITS-1] ? t_coef'(-i_cb) : i_cb;
                r_acc  <= '0;
            end else if (r_busy) begin
                r_acc <= (r_acc << 1) + (r_ma[COEF_BITS-1] ? r_ta : '0)
                       + (r_mb[COEF_BITS-1] ? r_tb : '0);
                r_ma  <= r_ma << 1;
                r_mb  <= r_mb << 1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

FILE: hw/rtl/lehmer_xgcd_128_euclid_inner.sv
// Channel   Ports                                   Transaction
// --------  --------------------------------------  --------------------------
// operands  start, busy, i_m_hi/lo, i_n_hi/lo        start high while busy low
// result    o_valid, o_gcd_hi/lo, o_u_hi/lo, o_v_hi/lo  o_valid high one cycle
//
// Each outer round scans for the leading bit, then runs single-word Euclid
// steps on the shared divider, then six passes of the serial multiplier
// plus a sign fix-up of x and then of y; a round with no accepted step is
// one WORD_BITS-bit division. Synchronous active-low reset returns to idle;
// busy stays high from the accepted transaction until the result cycle.
// The receiver cannot stall.
module lehmer_xgcd_128_euclid_inner import lxgcd_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int LEAD_BITS = LEAD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [HI_BITS-1:0]   i_m_hi,
    input  logic [HALF_BITS-1:0] i_m_lo,
    input  logic [HI_BITS-1:0]   i_n_hi,
    input  logic [HALF_BITS-1:0] i_n_lo,
    output logic                 o_valid,
    output logic [HI_BITS-1:0]   o_gcd_hi,
    output logic [HALF_BITS-1:0] o_gcd_lo,
    output logic [HALF_BITS-1:0] o_u_hi,
    output logic [HALF_BITS-1:0] o_u_lo,
    output logic [HALF_BITS-1:0] o_v_hi,
    output logic [HALF_BITS-1:0] o_v_lo
);

    localparam int W     = WORD_BITS;
    localparam int IW    = $clog2(W);
    localparam int NBW   = $clog2(W + 1);
    localparam int EXT_W = (W > 128) ? W : 128;

    typedef enum logic [3:0] {
        S_IDLE, S_TEST, S_SCAN, S_ILOOP, S_IWAIT, S_ICHK,
        S_ODIV, S_OWAIT, S_MIX, S_MWAIT, S_FIXX, S_FIXY, S_FINAL
    } t_state;

    t_state        r_state;
    logic [W-1:0]  r_x, r_y, r_xa, r_xb, r_ya, r_yb, r_t;
    t_half         r_hm, r_hn, r_e, r_f, r_g, r_h;
    logic [IW-1:0] r_idx;
    logic          r_odd, r_any;
    logic [2:0]    r_mix;
    logic          r_valid;
    logic [EXT_W-1:0] r_gx, r_gu, r_gv;

    // Divider hookup
    logic          div_go, div_done;
    logic [IW-1:0] div_top;
    logic [W-1:0]  div_a, div_d, div_p, div_q, div_r, div_s;
    logic [W-1:0]  div_rem, div_po, div_ro;

    // Multiplier hookup
    logic          mac_go, mac_done;
    logic [W-1:0]  mac_a, mac_b, mac_acc;
    t_coef         mac_ca, mac_cb;

    logic [W-1:0]  xy_or, x_sh, y_sh;
    logic [NBW-1:0] nb, kx;
    logic          stop;
    logic signed [HALF_BITS-1:0] s_hn, s_lhs, s_a, s_b;

    assign xy_or = r_x | r_y;
    assign nb    = NBW'(r_idx) + 1'b1;
    assign kx    = (nb > NBW'(LEAD_BITS)) ? NBW'(nb - NBW'(LEAD_BITS)) : '0;
    assign x_sh  = r_x >> kx;
    assign y_sh  = r_y >> kx;

    // Jebelean-style test; its form alternates with the step parity.
    assign s_hn  = r_hn;
    assign s_lhs = r_hm - r_hn;
    assign s_a   = r_odd ? t_half'(-r_g) : t_half'(-r_h);
    assign s_b   = r_odd ? t_half'(r_h - r_f) : t_half'(r_g - r_e);
    assign stop  = (s_hn < s_a) || (s_lhs < s_b);

    always_comb begin
        div_go  = 1'b0;
        div_top = IW'(W - 1);
        div_a   = r_x;
        div_d   = r_y;
        div_p   = r_xa;
        div_q   = r_ya;
        div_r   = r_xb;
        div_s   = r_yb;
        if (r_state == S_ILOOP) begin
            div_go  = (r_hn != '0);
            div_top = IW'(HALF_BITS - 1);
            div_a   = W'(r_hm);
            div_d   = W'(r_hn);
            div_p   = W'(r_f);
            div_q   = W'(r_h);
            div_r   = W'(r_e);
            div_s   = W'(r_g);
        end else if (r_state == S_ODIV) begin
            div_go = 1'b1;
        end
    end

    always_comb begin
        mac_go = (r_state == S_MIX);
        case (r_mix[2:1])
            2'd0:    begin mac_a = r_x;  mac_b = r_y;  end
            2'd1:    begin mac_a = r_xa; mac_b = r_ya; end
            default: begin mac_a = r_xb; mac_b = r_yb; end
        endcase
        mac_ca = r_mix[0] ? r_g : r_e;
        mac_cb = r_mix[0] ? r_h : r_f;
    end

    lxgcd_div #(.W(W)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (div_go),
        .i_top  (div_top),
        .i_a    (div_a),
        .i_d    (div_d),
        .i_p    (div_p),
        .i_q    (div_q),
        .i_r    (div_r),
        .i_s    (div_s),
        .o_done (div_done),
        .o_rem  (div_rem),
        .o_p    (div_po),
        .o_r    (div_ro)
    );

    lxgcd_mac #(.W(W)) u_mac (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (mac_go),
        .i_a    (mac_a),
        .i_b    (mac_b),
        .i_ca   (mac_ca),
        .i_cb   (mac_cb),
        .o_done (mac_done),
        .o_acc  (mac_acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_x     <= W'({i_m_hi, i_m_lo});
                        r_y     <= W'({i_n_hi, i_n_lo});
                        r_xa    <= W'(1);
                        r_xb    <= '0;
                        r_ya    <= '0;
                        r_yb    <= W'(1);
                        r_state <= S_TEST;
                    end
                end
                S_TEST: begin
                    r_idx   <= IW'(W - 1);
                    r_state <= (r_y == '0) ? S_FINAL : S_SCAN;
                end
                S_SCAN: begin
                    if (xy_or[r_idx] || r_idx == '0) begin
                        r_hm    <= t_half'(x_sh);
                        r_hn    <= t_half'(y_sh);
                        r_e     <= t_half'(1);
                        r_f     <= '0;
                        r_g     <= '0;
                        r_h     <= t_half'(1);
                        r_odd   <= 1'b0;
                        r_any   <= 1'b0;
                        r_state <= S_ILOOP;
                    end else begin
                        r_idx <= r_idx - 1'b1;
                    end
                end
                S_ILOOP: begin
                    if (r_hn != '0) begin
                        r_state <= S_IWAIT;
                    end else begin
                        r_mix   <= '0;
                        r_state <= r_any ? S_MIX : S_ODIV;
                    end
                end
                S_IWAIT: begin
                    if (div_done) begin
                        r_hm    <= r_hn;
                        r_hn    <= t_half'(div_rem);
                        r_f     <= r_h;
                        r_h     <= t_half'(div_po);
                        r_e     <= r_g;
                        r_g     <= t_half'(div_ro);
                        r_state <= S_ICHK;
                    end
                end
                S_ICHK: begin
                    // The failing step still belongs to the matrix.
                    if (stop) begin
                        r_mix   <= '0;
                        r_state <= r_any ? S_MIX : S_ODIV;
                    end else begin
                        r_odd   <= ~r_odd;
                        r_any   <= 1'b1;
                        r_state <= S_ILOOP;
                    end
                end
                S_ODIV: r_state <= S_OWAIT;
                S_OWAIT: begin
                    if (div_done) begin
                        r_x     <= r_y;
                        r_y     <= div_rem;
                        r_xa    <= r_ya;
                        r_ya    <= div_po;
                        r_xb    <= r_yb;
                        r_yb    <= div_ro;
                        r_state <= S_TEST;
                    end
                end
                S_MIX: r_state <= S_MWAIT;
                S_MWAIT: begin
                    if (mac_done) begin
                        if (!r_mix[0]) begin
                            r_t <= mac_acc;
                        end else begin
                            case (r_mix[2:1])
                                2'd0:    begin r_x  <= r_t; r_y  <= mac_acc; end
                                2'd1:    begin r_xa <= r_t; r_ya <= mac_acc; end
                                default: begin r_xb <= r_t; r_yb <= mac_acc; end
                            endcase
                        end
                        if (r_mix == 3'd5) begin
                            r_state <= S_FIXX;
                        end else begin
                            r_mix   <= r_mix + 1'b1;
                            r_state <= S_MIX;
                        end
                    end
                end
                S_FIXX: begin
                    if (r_x[W-1]) begin
                        r_x  <= W'(-r_x);
                        r_xa <= W'(-r_xa);
                        r_xb <= W'(-r_xb);
                    end
                    r_state <= S_FIXY;
                end
                S_FIXY: begin
                    if (r_y[W-1]) begin
                        r_y  <= W'(-r_y);
                        r_ya <= W'(-r_ya);
                        r_yb <= W'(-r_yb);
                    end
                    r_state <= S_TEST;
                end
                S_FINAL: begin
                    r_gx    <= EXT_W'($signed(r_x[W-1] ? W'(-r_x) : r_x));
                    r_gu    <= EXT_W'($signed(r_x[W-1] ? W'(-r_xa) : r_xa));
                    r_gv    <= EXT_W'($signed(r_x[W-1] ? W'(-r_xb) : r_xb));
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_gcd_hi = r_gx[126:64];
    assign o_gcd_lo = r_gx[63:0];
    assign o_u_hi   = r_gu[127:64];
    assign o_u_lo   = r_gu[63:0];
    assign o_v_hi   = r_gv[127:64];
    assign o_v_lo   = r_gv[63:0];

endmodule
